### hw/rtl/amsu_pkg.sv
// Shared types and constants for the actuator move supervisor.
// Used by amsu_csr, amsu_core and the top level; depends on nothing.

package amsu_pkg;

   // Number of actuators that the sensor and drive buses carry.
   localparam int unsigned ACT_COUNT = 8;
   localparam int unsigned ACT_IDX_W = $clog2(ACT_COUNT);

   // Commands carried by an input beat.
   typedef enum logic [1:0] {
      CMD_START = 2'd0,
      CMD_TICK  = 2'd1,
      CMD_POLL  = 2'd2
   } cmd_type;

   // Result status codes.
   localparam logic [1:0] ST_IDLE      = 2'd0;
   localparam logic [1:0] ST_MOVING    = 2'd1;
   localparam logic [1:0] ST_SUCCEEDED = 2'd2;
   localparam logic [1:0] ST_FAILED    = 2'd3;

   // Button tracking codes; the fourth code reads as not armed.
   localparam logic [1:0] BTN_IDLE    = 2'd0;
   localparam logic [1:0] BTN_ARMED   = 2'd1;
   localparam logic [1:0] BTN_PRESSED = 2'd2;

   // Register indexes (byte address is four times the index).
   localparam logic [2:0] REG_CURRENT_LIMIT = 3'd0;
   localparam logic [2:0] REG_OVER_SAMPLES  = 3'd1;
   localparam logic [2:0] REG_SETTLE        = 3'd2;
   localparam logic [2:0] REG_TIMEOUT       = 3'd3;
   localparam logic [2:0] REG_PRESCALE      = 3'd4;

   localparam int unsigned CSR_ADDR_W = 5;

   // Register reset values.
   localparam logic [15:0] RST_CURRENT_LIMIT = 16'd50000;
   localparam logic [9:0]  RST_OVER_SAMPLES  = 10'd1000;
   localparam logic [9:0]  RST_SETTLE        = 10'd500;
   localparam logic [15:0] RST_TIMEOUT       = 16'd60000;
   localparam logic [3:0]  RST_PRESCALE      = 4'd3;

   typedef struct packed {
      logic [15:0] current_limit;
      logic [9:0]  overcurrent_samples;
      logic [9:0]  settle_samples;
      logic [15:0] timeout_ticks;
      logic [3:0]  prescale_max;
   } cfg_type;

   typedef struct packed {
      cmd_type     command;
      logic [3:0]  channel;
      logic        direction;
      logic [7:0]  back_sense;
      logic [7:0]  out_sense;
      logic [15:0] current_sample;
      logic        button_level;
   } item_type;

   typedef struct packed {
      logic [1:0] status;
      logic       move_done;
      logic [7:0] dir_lines;
      logic [7:0] enable_lines;
      logic       button_pressed;
   } result_type;

endpackage

### hw/rtl/amsu_csr.sv
// Configuration register file of the actuator move supervisor.
// APB-style write and read access; depends on amsu_pkg.

module amsu_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [amsu_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [31:0]                         pwdata,
   output logic [31:0]                         prdata,
   output logic                                pready,
   output amsu_pkg::cfg_type                   cfg
);
   import amsu_pkg::*;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic [2:0] reg_idx;
   logic       wr_en;

   assign reg_idx = paddr[4:2];
   assign wr_en   = psel & penable & pwrite;
   assign pready  = 1'b1;
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_CURRENT_LIMIT: cfg_in.current_limit       = pwdata[15:0];
            REG_OVER_SAMPLES:  cfg_in.overcurrent_samples = pwdata[9:0];
            REG_SETTLE:        cfg_in.settle_samples      = pwdata[9:0];
            REG_TIMEOUT:       cfg_in.timeout_ticks       = pwdata[15:0];
            REG_PRESCALE:      cfg_in.prescale_max        = pwdata[3:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_CURRENT_LIMIT: prdata = {16'd0, cfg_ff.current_limit};
         REG_OVER_SAMPLES:  prdata = {22'd0, cfg_ff.overcurrent_samples};
         REG_SETTLE:        prdata = {22'd0, cfg_ff.settle_samples};
         REG_TIMEOUT:       prdata = {16'd0, cfg_ff.timeout_ticks};
         REG_PRESCALE:      prdata = {28'd0, cfg_ff.prescale_max};
         default:           prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.current_limit       <= RST_CURRENT_LIMIT;
         cfg_ff.overcurrent_samples <= RST_OVER_SAMPLES;
         cfg_ff.settle_samples      <= RST_SETTLE;
         cfg_ff.timeout_ticks       <= RST_TIMEOUT;
         cfg_ff.prescale_max        <= RST_PRESCALE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### hw/rtl/amsu_core.sv
// Move state and single-pass item evaluation of the actuator move supervisor.
// Updates its state when an item is processed; depends on amsu_pkg.

module amsu_core (
   input  logic                 clock,
   input  logic                 reset,
   input  amsu_pkg::cfg_type    cfg,
   input  amsu_pkg::item_type   item,
   input  logic                 fire,
   output amsu_pkg::result_type result
);
   import amsu_pkg::*;

   logic                 moving_ff, moving_in;
   logic [ACT_IDX_W-1:0] chan_ff, chan_in;
   logic                 adir_ff, adir_in;
   logic [9:0]           settle_ff, settle_in;
   logic [9:0]           over_ff, over_in;
   logic [3:0]           presc_ff, presc_in;
   logic [15:0]          tmo_ff, tmo_in;
   logic [1:0]           btn_ff, btn_in;
   logic [7:0]           dir_ff, dir_in;
   logic [7:0]           en_ff, en_in;

   logic                 chan_ok;
   logic [ACT_IDX_W-1:0] start_idx;
   logic                 start_at;
   logic                 tick_at;
   logic                 over_now;
   logic                 settle_stop;
   logic                 over_stop;
   logic                 presc_wrap;
   logic [15:0]          tmo_step;
   logic                 tick_stop;
   logic [3:0]           chan_m1;

   assign chan_m1   = item.channel - 4'd1;
   assign chan_ok   = (item.channel != 4'd0) && ({28'd0, item.channel} <= ACT_COUNT);
   assign start_idx = chan_m1[ACT_IDX_W-1:0];
   assign start_at  = item.direction ? item.out_sense[start_idx] : item.back_sense[start_idx];
   assign tick_at   = adir_ff ? item.out_sense[chan_ff] : item.back_sense[chan_ff];
   assign over_now  = item.current_sample > cfg.current_limit;

   assign settle_stop = tick_at && (settle_ff >= cfg.settle_samples);
   assign over_stop   = over_now && (over_ff >= cfg.overcurrent_samples);
   assign presc_wrap  = presc_ff >= cfg.prescale_max;
   assign tmo_step    = (presc_wrap && (tmo_ff != 16'hFFFF)) ? tmo_ff + 16'd1 : tmo_ff;
   assign tick_stop   = settle_stop || over_stop || (tmo_step >= cfg.timeout_ticks);

   always_comb begin
      moving_in = moving_ff;
      chan_in   = chan_ff;
      adir_in   = adir_ff;
      settle_in = settle_ff;
      over_in   = over_ff;
      presc_in  = presc_ff;
      tmo_in    = tmo_ff;
      btn_in    = btn_ff;
      dir_in    = dir_ff;
      en_in     = en_ff;
      result.status    = moving_ff ? ST_MOVING : ST_IDLE;
      result.move_done = 1'b0;

      unique case (item.command)
         CMD_START: begin
            if (!moving_ff) begin
               result.move_done = 1'b1;
               result.status    = ST_FAILED;
               if (chan_ok) begin
                  if (start_at) begin
                     result.status = ST_SUCCEEDED;
                     btn_in        = BTN_ARMED;
                  end else if (cfg.timeout_ticks != 16'd0) begin
                     moving_in          = 1'b1;
                     chan_in            = start_idx;
                     adir_in            = item.direction;
                     settle_in          = 10'd0;
                     over_in            = 10'd0;
                     presc_in           = 4'd0;
                     tmo_in             = 16'd0;
                     dir_in[start_idx]  = ~item.direction;
                     en_in[start_idx]   = 1'b1;
                     result.status      = ST_MOVING;
                     result.move_done   = 1'b0;
                  end
               end
            end
         end
         CMD_TICK: begin
            if (moving_ff) begin
               settle_in = !tick_at ? 10'd0 : (settle_stop ? settle_ff : settle_ff + 10'd1);
               over_in   = !over_now ? 10'd0 : (over_stop ? over_ff : over_ff + 10'd1);
               presc_in  = presc_wrap ? 4'd0 : presc_ff + 4'd1;
               tmo_in    = tmo_step;
               if (tick_stop) begin
                  dir_in[chan_ff]  = 1'b0;
                  en_in[chan_ff]   = 1'b0;
                  moving_in        = 1'b0;
                  result.move_done = 1'b1;
                  if (tick_at) begin
                     result.status = ST_SUCCEEDED;
                     btn_in        = BTN_ARMED;
                  end else begin
                     result.status = ST_FAILED;
                  end
               end
            end
         end
         CMD_POLL: begin
            if ((btn_ff == BTN_ARMED) && !item.button_level) begin
               btn_in = BTN_PRESSED;
            end
         end
         default: ;
      endcase

      result.dir_lines      = dir_in;
      result.enable_lines   = en_in;
      result.button_pressed = (btn_in == BTN_PRESSED);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         moving_ff <= 1'b0;
         chan_ff   <= '0;
         adir_ff   <= 1'b0;
         settle_ff <= 10'd0;
         over_ff   <= 10'd0;
         presc_ff  <= 4'd0;
         tmo_ff    <= 16'd0;
         btn_ff    <= BTN_IDLE;
         dir_ff    <= 8'd0;
         en_ff     <= 8'd0;
      end else if (fire) begin
         moving_ff <= moving_in;
         chan_ff   <= chan_in;
         adir_ff   <= adir_in;
         settle_ff <= settle_in;
         over_ff   <= over_in;
         presc_ff  <= presc_in;
         tmo_ff    <= tmo_in;
         btn_ff    <= btn_in;
         dir_ff    <= dir_in;
         en_ff     <= en_in;
      end
   end

endmodule

### hw/rtl/actuator_move_supervisor_unit.sv
// Top level of the actuator move supervisor: input register, result register,
// handshakes and the instances of amsu_csr and amsu_core; depends on amsu_pkg.
//
// Usage: each beat on the req_ channel carries one command (start a move,
// sample tick or button poll) with the sensor, current and button readings
// that go with it. Every accepted beat yields exactly one result beat on the
// rsp_ channel with the status, the done flag, the drive lines and the
// latched button flag, in the order the beats were accepted.
// A beat is captured in the input register; when the result register is empty
// or draining, the move state is updated and the result register is loaded.
// Throughput is one beat per cycle when rsp_ready holds; the only loop is the
// move state, read and written in the same cycle by the single evaluation stage.
// When the receiver stalls, the result register holds its beat and the input
// register keeps taking a beat as long as the result register can drain into
// the receiver or is empty; req_ready drops only when both are full and
// rsp_ready is low.
// Reset (synchronous, active high) empties both registers, stops any move,
// clears all drive lines and the button flag, and loads the default
// configuration. The user must write configuration through the APB-style port
// only while no beat is in flight; the block itself does not enforce this.

module actuator_move_supervisor_unit (
   input  logic                            clock,
   input  logic                            reset,
   // Input channel
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [1:0]                      req_command,
   input  logic [3:0]                      req_channel,
   input  logic                            req_direction,
   input  logic [7:0]                      req_back_sense,
   input  logic [7:0]                      req_out_sense,
   input  logic [15:0]                     req_current_sample,
   input  logic                            req_button_level,
   // Result channel
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [1:0]                      rsp_status,
   output logic                            rsp_move_done,
   output logic [7:0]                      rsp_dir_lines,
   output logic [7:0]                      rsp_enable_lines,
   output logic                            rsp_button_pressed,
   // Configuration port
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [amsu_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                     pwdata,
   output logic [31:0]                     prdata,
   output logic                            pready
);
   import amsu_pkg::*;

   cfg_type    cfg;
   item_type   item_ff;
   item_type   item_in;
   logic       item_vld_ff;
   result_type res_ff;
   result_type res_in;
   logic       rsp_vld_ff;
   logic       out_free;
   logic       fire;
   logic       req_fire;

   // The result register can take a new beat when it is empty or draining.
   assign out_free  = !rsp_vld_ff || rsp_ready;
   assign fire      = item_vld_ff && out_free;
   assign req_ready = !item_vld_ff || out_free;
   assign req_fire  = req_valid && req_ready;

   assign item_in.command        = cmd_type'(req_command);
   assign item_in.channel        = req_channel;
   assign item_in.direction      = req_direction;
   assign item_in.back_sense     = req_back_sense;
   assign item_in.out_sense      = req_out_sense;
   assign item_in.current_sample = req_current_sample;
   assign item_in.button_level   = req_button_level;

   amsu_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // The core evaluates the held beat and commits its state on fire.
   amsu_core u_core (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .item   (item_ff),
      .fire   (fire),
      .result (res_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         item_vld_ff <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         if (req_fire) begin
            item_vld_ff <= 1'b1;
         end else if (fire) begin
            item_vld_ff <= 1'b0;
         end
         if (fire) begin
            rsp_vld_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_vld_ff <= 1'b0;
         end
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         item_ff <= item_in;
      end
      if (fire) begin
         res_ff <= res_in;
      end
   end

   assign rsp_valid          = rsp_vld_ff;
   assign rsp_status         = res_ff.status;
   assign rsp_move_done      = res_ff.move_done;
   assign rsp_dir_lines      = res_ff.dir_lines;
   assign rsp_enable_lines   = res_ff.enable_lines;
   assign rsp_button_pressed = res_ff.button_pressed;

endmodule
